### hdl/disjoint_sparse_table_range_sum_top_macros.svh
// assertion macros used by the checker file
`ifndef DISJOINT_SPARSE_TABLE_RANGE_SUM_TOP_MACROS_SVH
`define DISJOINT_SPARSE_TABLE_RANGE_SUM_TOP_MACROS_SVH

// concurrent assertion, switched off while reset is held
`define DSRS_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent assertion that also runs during reset
`define DSRS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/dsrs_pkg.sv
// shared types and constants for the disjoint sparse table range sum block
`default_nettype none

package dsrs_pkg;

  localparam int VAL_W = 32;
  localparam int IDX_W = 10;
  localparam int H_W   = $clog2(IDX_W);

  localparam int DEF_MAX_ELEMENTS = 1024;
  localparam int DEF_LEVELS       = 10;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load_wr;
    logic q_issue;
    logic q_err;
    logic b_issue;
    logic b_first;
    logic b_zero;
  } dsrs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic q_room;
    logic q1_valid;
  } dsrs_sts_t;

endpackage

`default_nettype wire

### hdl/dsrs_if.sv
// request and result channel interfaces
`default_nettype none

interface dsrs_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  operation;
  logic signed [dsrs_pkg::VAL_W-1:0]     value;
  logic                                  last;
  logic        [dsrs_pkg::IDX_W-1:0]     left_index;
  logic        [dsrs_pkg::IDX_W-1:0]     right_index;

  modport source (output valid, output operation, output value, output last,
                  output left_index, output right_index, input ready);
  modport sink   (input valid, input operation, input value, input last,
                  input left_index, input right_index, output ready);
endinterface

interface dsrs_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [dsrs_pkg::VAL_W-1:0]     range_sum;
  logic                                  error;

  modport source (output valid, output range_sum, output error, input ready);
  modport sink   (input valid, input range_sum, input error, output ready);
endinterface

`default_nettype wire

### hdl/dsrs_ctrl.sv
// controller: request decode, element count, build sequencer
`default_nettype none

module dsrs_ctrl #(
  parameter int MAX_ELEMENTS = dsrs_pkg::DEF_MAX_ELEMENTS,
  parameter int LEVELS       = dsrs_pkg::DEF_LEVELS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  logic                          in_last,
  input  logic [dsrs_pkg::IDX_W-1:0]    in_left,
  input  logic [dsrs_pkg::IDX_W-1:0]    in_right,
  input  dsrs_pkg::dsrs_sts_t           sts,
  output dsrs_pkg::dsrs_cmd_t           cmd,
  output logic [$clog2(MAX_ELEMENTS)-1:0] ld_pos,
  output logic [$clog2(MAX_ELEMENTS)-1:0] b_pos,
  output logic [((LEVELS > 1) ? $clog2(LEVELS) : 1)-1:0] b_lvl
);

  localparam int PW    = $clog2(MAX_ELEMENTS);
  localparam int NW    = PW + 1;
  localparam int CW    = $clog2(MAX_ELEMENTS + 1);
  localparam int LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int LE_W  = $clog2(PW + LEVELS + 1);
  localparam int CMP_W = (CW > dsrs_pkg::IDX_W) ? CW : dsrs_pkg::IDX_W;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_BSTART = 4'b0010,
    ST_BUILD  = 4'b0100,
    ST_BDRAIN = 4'b1000
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt, count_base;
  logic            built_r, built_nxt;
  logic [LE_W-1:0] lvl_r, lvl_nxt, lvl_end_r, lvl_end_nxt, lg;
  logic [NW-1:0]   half_r, half_nxt, n_r, n_nxt, base_r, base_nxt;
  logic [NW-1:0]   base_step, pos_full;
  logic [PW-1:0]   off_r, off_nxt;
  logic            side_r, side_nxt;
  logic            accept, room, half_done;

  assign in_ready   = (state_r == ST_IDLE) && sts.q_room;
  assign accept     = in_valid && in_ready;
  assign count_base = built_r ? '0 : count_r;
  assign room       = count_base < CW'(MAX_ELEMENTS);
  assign ld_pos     = PW'(count_base);

  // ceil(log2(count))
  always_comb begin
    lg = '0;
    for (int k = 0; k < PW; k++) begin
      if (32'(count_r) > (32'd1 << k)) lg = LE_W'(k + 1);
    end
  end

  // right half runs up from the middle, left half runs down from it
  assign pos_full  = side_r ? (base_r + half_r - NW'(1) - NW'(off_r))
                            : (base_r + half_r + NW'(off_r));
  assign b_pos     = pos_full[PW-1:0];
  assign b_lvl     = LVL_W'(lvl_r);
  assign half_done = (NW'(off_r) == (half_r - NW'(1)));
  assign base_step = base_r + (half_r << 1);

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    built_nxt   = built_r;
    lvl_nxt     = lvl_r;
    lvl_end_nxt = lvl_end_r;
    half_nxt    = half_r;
    n_nxt       = n_r;
    base_nxt    = base_r;
    off_nxt     = off_r;
    side_nxt    = side_r;
    cmd         = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_op == dsrs_pkg::OP_LOAD) begin
            built_nxt   = 1'b0;
            count_nxt   = count_base + CW'(room);
            cmd.load_wr = room;
            if (in_last) state_nxt = ST_BSTART;
          end else begin
            cmd.q_issue = 1'b1;
            cmd.q_err   = !built_r || (in_left > in_right) ||
                          (CMP_W'(in_right) >= CMP_W'(count_r));
          end
        end
      end
      ST_BSTART: begin
        lvl_end_nxt = (lg < LE_W'(LEVELS)) ? lg : LE_W'(LEVELS);
        n_nxt       = NW'(1) << lg;
        lvl_nxt     = LE_W'(1);
        half_nxt    = NW'(2);
        base_nxt    = '0;
        off_nxt     = '0;
        side_nxt    = 1'b0;
        state_nxt   = (lvl_end_nxt > LE_W'(1)) ? ST_BUILD : ST_BDRAIN;
      end
      ST_BUILD: begin
        if (!sts.q1_valid) begin
          cmd.b_issue = 1'b1;
          cmd.b_first = (off_r == '0);
          cmd.b_zero  = (pos_full >= NW'(count_r));
          if (!half_done) begin
            off_nxt = off_r + PW'(1);
          end else begin
            off_nxt = '0;
            if (!side_r) begin
              side_nxt = 1'b1;
            end else begin
              side_nxt = 1'b0;
              if (base_step >= n_r) begin
                base_nxt = '0;
                lvl_nxt  = lvl_r + LE_W'(1);
                half_nxt = half_r << 1;
                if ((lvl_r + LE_W'(1)) >= lvl_end_r) state_nxt = ST_BDRAIN;
              end else begin
                base_nxt = base_step;
              end
            end
          end
        end
      end
      ST_BDRAIN: begin
        built_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      built_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      built_r <= built_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lvl_r     <= lvl_nxt;
    lvl_end_r <= lvl_end_nxt;
    half_r    <= half_nxt;
    n_r       <= n_nxt;
    base_r    <= base_nxt;
    off_r     <= off_nxt;
    side_r    <= side_nxt;
  end

endmodule

`default_nettype wire

### hdl/dsrs_dp.sv
// datapath: level table memory, build accumulator, query adder, result register
`default_nettype none

module dsrs_dp #(
  parameter int MAX_ELEMENTS = dsrs_pkg::DEF_MAX_ELEMENTS,
  parameter int LEVELS       = dsrs_pkg::DEF_LEVELS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  dsrs_pkg::dsrs_cmd_t                   cmd,
  input  logic [$clog2(MAX_ELEMENTS)-1:0]       ld_pos,
  input  logic [$clog2(MAX_ELEMENTS)-1:0]       b_pos,
  input  logic [((LEVELS > 1) ? $clog2(LEVELS) : 1)-1:0] b_lvl,
  input  logic signed [dsrs_pkg::VAL_W-1:0]     in_value,
  input  logic [dsrs_pkg::IDX_W-1:0]            in_left,
  input  logic [dsrs_pkg::IDX_W-1:0]            in_right,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [dsrs_pkg::VAL_W-1:0]     out_sum,
  output logic                                  out_err,
  output dsrs_pkg::dsrs_sts_t                   sts
);

  localparam int PW        = $clog2(MAX_ELEMENTS);
  localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int MEM_DEPTH = LEVELS * (1 << PW);
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int VW        = dsrs_pkg::VAL_W;

  logic [VW-1:0] mem [MEM_DEPTH];

  logic [dsrs_pkg::IDX_W-1:0] x;
  logic [dsrs_pkg::H_W-1:0]   h;
  logic                       q_hi;
  logic [LVL_W-1:0]           q_lvl;
  logic [PW-1:0]              ql_pos, qr_pos;
  logic [AW-1:0]              ra, rb, wa, bs_addr_r;
  logic [VW-1:0]              wd, rd_a_r, rd_b_r, acc_r, bs_elem, bsum;
  logic                       we, rd_a_en;
  logic                       bs_valid_r, bs_first_r, bs_zero_r;
  logic                       q1_valid_r, q1_err_r, q1_same_r, q1_hi_r;
  logic                       out_valid_r, out_err_r;
  logic [VW-1:0]              out_sum_r;
  logic                       out_free, q1_move;

  // level = highest differing bit of the two ends
  assign x = in_left ^ in_right;
  always_comb begin
    h = '0;
    for (int k = 0; k < dsrs_pkg::IDX_W; k++) begin
      if (x[k]) h = dsrs_pkg::H_W'(k);
    end
  end

  assign q_hi   = int'(h) >= LEVELS;
  assign q_lvl  = q_hi ? '0 : LVL_W'(h);
  assign ql_pos = PW'(in_left);
  assign qr_pos = PW'(in_right);

  assign rd_a_en = cmd.q_issue || cmd.b_issue;
  assign ra      = cmd.b_issue ? AW'(b_pos) : AW'({q_lvl, ql_pos});
  assign rb      = AW'({q_lvl, qr_pos});

  // running suffix or prefix sum; padding past the count reads as zero
  assign bs_elem = bs_zero_r ? '0 : rd_a_r;
  assign bsum    = (bs_first_r ? '0 : acc_r) + bs_elem;

  assign we = bs_valid_r || cmd.load_wr;
  assign wa = bs_valid_r ? bs_addr_r : AW'(ld_pos);
  assign wd = bs_valid_r ? bsum : $unsigned(in_value);

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (rd_a_en) rd_a_r <= mem[ra];
    if (cmd.q_issue) rd_b_r <= mem[rb];
  end

  assign out_free = !out_valid_r || out_ready;
  assign q1_move  = q1_valid_r && out_free;

  assign sts.q_room   = !q1_valid_r || out_free;
  assign sts.q1_valid = q1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bs_valid_r  <= 1'b0;
      q1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      bs_valid_r  <= cmd.b_issue;
      q1_valid_r  <= cmd.q_issue || (q1_valid_r && !out_free);
      out_valid_r <= q1_move || (out_valid_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.b_issue) begin
      bs_first_r <= cmd.b_first;
      bs_zero_r  <= cmd.b_zero;
      bs_addr_r  <= AW'({b_lvl, b_pos});
    end
    if (bs_valid_r) acc_r <= bsum;
    if (cmd.q_issue) begin
      q1_err_r  <= cmd.q_err;
      q1_same_r <= (in_left == in_right);
      q1_hi_r   <= q_hi;
    end
    if (q1_move) begin
      out_err_r <= q1_err_r;
      if (q1_err_r || q1_hi_r) begin
        out_sum_r <= '0;
      end else if (q1_same_r) begin
        out_sum_r <= rd_a_r;
      end else begin
        out_sum_r <= rd_a_r + rd_b_r;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_sum   = $signed(out_sum_r);
  assign out_err   = out_err_r;

endmodule

`default_nettype wire

### hdl/disjoint_sparse_table_range_sum_top.sv
// top level of the disjoint sparse table range sum block
//
//   channel  dir  handshake        payload
//   in_ch    in   valid / ready    operation, value, last, left_index, right_index
//   out_ch   out  valid / ready    range_sum, error
//
// loads and queries are taken one per cycle while the controller is idle and
// the query stage has room; a query result passes the read register, then the
// output register, and waits there under stall; a last-marked load starts the
// build: input stays blocked through the start state, the walk over levels 1
// to L-1 and the drain state, L = min(lg, LEVELS), lg = ceil(log2(count)), and
// longer while a waiting result holds off the first build read; one table entry
// is written per cycle through the single write port of the level table memory
// reset clears count, built flag and handshake state; the table itself is
// never cleared and only entries written since the current array began are read
`default_nettype none

module disjoint_sparse_table_range_sum_top #(
  parameter int MAX_ELEMENTS = dsrs_pkg::DEF_MAX_ELEMENTS,
  parameter int LEVELS       = dsrs_pkg::DEF_LEVELS
) (
  input  logic     clk,
  input  logic     rst_n,
  dsrs_in_if.sink  in_ch,
  dsrs_out_if.source out_ch
);

  localparam int PW    = $clog2(MAX_ELEMENTS);
  localparam int LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  dsrs_pkg::dsrs_cmd_t cmd;
  dsrs_pkg::dsrs_sts_t sts;
  logic [PW-1:0]       ld_pos;     // level 0 slot of the next load
  logic [PW-1:0]       b_pos;      // position handled by the build this cycle
  logic [LVL_W-1:0]    b_lvl;      // level being built

  // controller owns the count, the built flag and the build walk
  dsrs_ctrl #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .LEVELS       (LEVELS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_op    (in_ch.operation),
    .in_last  (in_ch.last),
    .in_left  (in_ch.left_index),
    .in_right (in_ch.right_index),
    .sts      (sts),
    .cmd      (cmd),
    .ld_pos   (ld_pos),
    .b_pos    (b_pos),
    .b_lvl    (b_lvl)
  );

  // datapath owns the table memory, the build sum and the result register
  dsrs_dp #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .LEVELS       (LEVELS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .ld_pos    (ld_pos),
    .b_pos     (b_pos),
    .b_lvl     (b_lvl),
    .in_value  (in_ch.value),
    .in_left   (in_ch.left_index),
    .in_right  (in_ch.right_index),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_sum   (out_ch.range_sum),
    .out_err   (out_ch.error),
    .sts       (sts)
  );

endmodule

`default_nettype wire

### hdl/dsrs_checker.sv
// port-level checker for the range sum block, bound to the top level
`default_nettype none

`include "disjoint_sparse_table_range_sum_top_macros.svh"

module dsrs_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              in_operation,
  input logic                              in_last,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [dsrs_pkg::VAL_W-1:0] out_range_sum,
  input logic                              out_error
);

  `DSRS_ASSERT_RST(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped under stall")
  `DSRS_ASSERT_RST(a_err_zero, clk, rst_n, out_valid && out_error |-> out_range_sum == 0, "error result with nonzero sum")
  `DSRS_ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |=> !out_valid, "result valid right after reset")
  `DSRS_ASSERT_RST(a_build_stall, clk, rst_n, in_valid && in_ready && in_operation == dsrs_pkg::OP_LOAD && in_last |=> !in_ready, "request taken during build")

endmodule

bind disjoint_sparse_table_range_sum_top dsrs_checker u_dsrs_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_operation  (in_ch.operation),
  .in_last       (in_ch.last),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_range_sum (out_ch.range_sum),
  .out_error     (out_ch.error)
);

`default_nettype wire

### tb/sv/testbench.sv
// self-checking testbench for the disjoint sparse table range sum block
module testbench;
  import dsrs_pkg::*;

  localparam int MAX_ELEMS = DEF_MAX_ELEMENTS;

  // one request as it crosses the input channel
  typedef struct packed {
    logic                    operation;
    logic signed [VAL_W-1:0] value;
    logic                    last;
    logic [IDX_W-1:0]        left_index;
    logic [IDX_W-1:0]        right_index;
  } request_t;

  // keeps its own copy of the loaded array and predicts every query answer
  class range_sum_board;
    typedef struct {
      logic signed [VAL_W-1:0] sum;
      logic                    error;
    } sum_result_t;

    logic signed [VAL_W-1:0] elements [MAX_ELEMS];
    int unsigned             element_count;
    bit                      table_built;
    sum_result_t             pending_sums [$];
    int unsigned             fail_count;

    function new();
      element_count = 0;
      table_built   = 0;
      fail_count    = 0;
    endfunction

    // a range sum over the array equals the suffix plus prefix lookup
    function void note_request(request_t rq);
      sum_result_t      res;
      logic [VAL_W-1:0] acc;
      if (rq.operation == OP_LOAD) begin
        // a load after a finished build starts a new array
        if (table_built) begin
          table_built   = 0;
          element_count = 0;
        end
        // past capacity the value is dropped, the last mark still counts
        if (element_count < MAX_ELEMS) begin
          elements[element_count] = rq.value;
          element_count++;
        end
        if (rq.last) table_built = 1;
        return;
      end
      if (!table_built || rq.left_index > rq.right_index ||
          rq.right_index >= element_count) begin
        res.sum   = '0;
        res.error = 1'b1;
      end else begin
        acc = '0;
        for (int p = rq.left_index; p <= rq.right_index; p++) acc += elements[p];
        res.sum   = acc;
        res.error = 1'b0;
      end
      pending_sums.push_back(res);
    endfunction

    function void check_result(logic signed [VAL_W-1:0] sum, logic error);
      sum_result_t want;
      if (pending_sums.size() == 0) begin
        $display("%0t: unexpected result, sum %0d error %0b", $time, sum, error);
        fail_count++;
        return;
      end
      want = pending_sums.pop_front();
      if (sum !== want.sum) begin
        $display("%0t: range_sum mismatch, expected %0d actual %0d",
                 $time, want.sum, sum);
        fail_count++;
      end
      if (error !== want.error) begin
        $display("%0t: error mismatch, expected %0b actual %0b",
                 $time, want.error, error);
        fail_count++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  dsrs_in_if  in_ch ();
  dsrs_out_if out_ch ();

  disjoint_sparse_table_range_sum_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  range_sum_board board;

  int unsigned sent_count;   // requests accepted so far
  int unsigned burst_left;   // requests left in the current sender burst
  int unsigned stall_left;   // cycles left in the current receiver mode
  int unsigned stall_mode;
  int unsigned stall_phase;

  // free-running clock, period 10
  always #5 clk = ~clk;

  // watchdog: a hung handshake or a missing result ends here
  initial begin
    #8_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // bus monitor, sampled at the falling edge so that both sides are settled;
  // a handshake seen here completes at the next rising edge
  always @(negedge clk) begin : sample_bus
    request_t seen;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready)
        board.check_result(out_ch.range_sum, out_ch.error);
      if (in_ch.valid && in_ch.ready) begin
        seen.operation   = in_ch.operation;
        seen.value       = in_ch.value;
        seen.last        = in_ch.last;
        seen.left_index  = in_ch.left_index;
        seen.right_index = in_ch.right_index;
        board.note_request(seen);
      end
    end
  end

  // result side back-pressure: stretches of always ready, random ready,
  // one-in-four ready and short dead stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left  = 0;
      stall_phase = 0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = (stall_mode == 3) ? $urandom_range(1, 12) : $urandom_range(5, 60);
      end
      stall_left--;
      stall_phase++;
      case (stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        2: out_ch.ready <= (stall_phase % 4 == 0);
        default: out_ch.ready <= 1'b0;
      endcase
    end
  end

  // present one request and hold it until the handshake completes; the
  // sender runs in bursts, a gap of zero keeps valid high across bursts
  task automatic drive_request(input request_t rq);
    int unsigned gap;
    bit          fire;
    if (burst_left == 0) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: gap = 0;
        5, 6, 7, 8:    gap = $urandom_range(1, 4);
        default:       gap = $urandom_range(5, 25);
      endcase
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= rq.operation;
    in_ch.value       <= rq.value;
    in_ch.last        <= rq.last;
    in_ch.left_index  <= rq.left_index;
    in_ch.right_index <= rq.right_index;
    do begin
      @(negedge clk);
      fire = in_ch.ready;
      @(posedge clk);
    end while (!fire);
    sent_count++;
  endtask

  // loads carry random indices, the block ignores them
  task automatic send_load(input logic [VAL_W-1:0] v, input logic lst);
    request_t rq;
    rq.operation   = OP_LOAD;
    rq.value       = v;
    rq.last        = lst;
    rq.left_index  = IDX_W'($urandom);
    rq.right_index = IDX_W'($urandom);
    drive_request(rq);
  endtask

  // queries carry random value and last bits, the block ignores them
  task automatic send_query(input logic [IDX_W-1:0] lo, input logic [IDX_W-1:0] hi);
    request_t rq;
    rq.operation   = OP_QUERY;
    rq.value       = $urandom;
    rq.last        = 1'($urandom_range(0, 1));
    rq.left_index  = lo;
    rq.right_index = hi;
    drive_request(rq);
  endtask

  // element values lean toward the wrap-around extremes
  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'hffff_ffff;
      3:       return 32'h0000_0000;
      4:       return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  // load n elements, last on the final one; with noise, stray queries before
  // later loads hit the not-built error path
  task automatic load_array(input int unsigned n, input bit noise);
    for (int unsigned i = 0; i < n; i++) begin
      if (noise && $urandom_range(0, 15) == 0)
        send_query(IDX_W'($urandom), IDX_W'($urandom));
      send_load(pick_value(), i == n - 1);
    end
  endtask

  // mostly legal ranges over the current array, some inverted, past the
  // end or fully random
  task automatic run_queries(input int unsigned n);
    int unsigned cnt;
    int unsigned lo;
    int unsigned hi;
    int unsigned kind;
    for (int unsigned i = 0; i < n; i++) begin
      cnt  = board.element_count;
      kind = $urandom_range(0, 19);
      if (kind < 14 && cnt > 0) begin
        lo = $urandom_range(0, cnt - 1);
        hi = (kind == 0) ? lo : $urandom_range(lo, cnt - 1);
      end else if (kind < 16 && cnt >= 2) begin
        lo = $urandom_range(1, cnt - 1);
        hi = $urandom_range(0, lo - 1);
      end else if (kind < 18 && cnt < MAX_ELEMS) begin
        hi = $urandom_range(cnt, MAX_ELEMS - 1);
        lo = $urandom_range(0, hi);
      end else begin
        lo = $urandom_range(0, MAX_ELEMS - 1);
        hi = $urandom_range(0, MAX_ELEMS - 1);
      end
      send_query(IDX_W'(lo), IDX_W'(hi));
    end
  endtask

  initial begin
    int unsigned kind;
    int unsigned target;
    bit          full_done;

    board       = new();
    clk         = 1'b0;
    rst_n       = 1'b0;
    burst_left  = 0;
    sent_count  = 0;
    full_done   = 0;
    in_ch.valid       = 1'b0;
    in_ch.operation   = OP_LOAD;
    in_ch.value       = '0;
    in_ch.last        = 1'b0;
    in_ch.left_index  = '0;
    in_ch.right_index = '0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // query before any build
    send_query(0, 0);
    // five elements with both extremes, padded to eight by the build
    send_load(32'h8000_0000, 1'b0);
    send_load(32'h7fff_ffff, 1'b0);
    send_load(32'hffff_ffff, 1'b0);
    send_load(32'h0000_0000, 1'b0);
    send_load(32'h0000_0001, 1'b1);
    send_query(0, 0);
    send_query(1, 1);
    send_query(0, 1);       // min plus max gives -1
    send_query(1, 2);       // max plus -1
    send_query(0, 4);
    send_query(3, 4);
    send_query(2, 4);
    send_query(4, 4);
    send_query(3, 2);       // inverted
    send_query(0, 5);       // past the data
    send_query(1023, 1023);
    send_query(0, 1023);
    // a load after the build starts a one-element array
    send_load(32'h1234_5678, 1'b1);
    send_query(0, 0);
    send_query(0, 1);
    // two elements: a build with no upper levels
    send_load(32'h7fff_ffff, 1'b0);
    send_load(32'h7fff_ffff, 1'b1);
    send_query(0, 1);

    target = sent_count + 1750;
    while (sent_count < target) begin
      kind = $urandom_range(0, 19);
      if (!full_done && (kind == 0 || sent_count > 600)) begin
        // full capacity, at least two dropped loads, last mark on the final dropped one
        for (int unsigned i = 0; i < MAX_ELEMS + 2; i++)
          send_load(pick_value(), i == MAX_ELEMS + 1);
        send_query(0, IDX_W'(MAX_ELEMS - 1));
        send_query(IDX_W'(MAX_ELEMS - 1), IDX_W'(MAX_ELEMS - 1));
        send_query(511, 512);
        send_query(512, 511);
        run_queries(60);
        full_done = 1;
      end else if (kind <= 2) begin
        // broken sequence: loads with no last mark, queries answered with error;
        // the next array keeps appending to these elements
        repeat ($urandom_range(1, 8)) send_load(pick_value(), 1'b0);
        run_queries(3);
      end else begin
        if ($urandom_range(0, 9) == 0)
          load_array($urandom_range(41, 300), kind[0]);
        else
          load_array($urandom_range(1, 40), kind[0]);
        run_queries($urandom_range(8, 40));
      end
    end

    in_ch.valid <= 1'b0;
    while (board.pending_sums.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (board.fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/dsrs_pkg.sv
hdl/dsrs_if.sv
hdl/dsrs_ctrl.sv
hdl/dsrs_dp.sv
hdl/disjoint_sparse_table_range_sum_top.sv
hdl/dsrs_checker.sv
tb/sv/testbench.sv
